@@ rtl/core/mer_pkg.sv @@
// ----------------------------------------------------------------------------
// mer_pkg: shared types and microcode for the midpoint ellipse rasterizer
// Holds datapath widths, the control word layout, status flags, step
// addresses and the microcode ROM that drives the datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int RADIUS_BITS = 11;
  localparam int COORD_BITS  = 12;
  localparam int OUT_BITS    = COORD_BITS + 1;
  localparam int SQR_BITS    = 2 * RADIUS_BITS;        // radius squared
  localparam int MUL_BITS    = 2 * (RADIUS_BITS + 1);  // (2x+1)^2 fits here
  localparam int PROD_BITS   = 2 * MUL_BITS;
  localparam int DEC_BITS    = 48;
  localparam int STEP_BITS   = 6;
  localparam int CFG_IDX_BITS = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_X = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_Y = 2'd3;

  // quadrant of the last point of a pixel
  localparam logic [1:0] QUAD_LAST = 2'd3;

  // microcode entry points
  localparam logic [STEP_BITS-1:0] STEP_IDLE   = 6'd0;
  localparam logic [STEP_BITS-1:0] STEP_INIT   = 6'd1;
  localparam logic [STEP_BITS-1:0] STEP_CHECK  = 6'd7;
  localparam logic [STEP_BITS-1:0] STEP_EMIT   = 6'd16;
  localparam logic [STEP_BITS-1:0] STEP_ADV    = 6'd20;
  localparam logic [STEP_BITS-1:0] STEP_R1_NEG = 6'd29;
  localparam logic [STEP_BITS-1:0] STEP_R2     = 6'd33;
  localparam logic [STEP_BITS-1:0] STEP_R2_POS = 6'd40;
  localparam logic [STEP_BITS-1:0] STEP_FIN    = 6'd44;

  typedef enum logic [3:0] {
    SRC_ONE,
    SRC_RX,
    SRC_RY,
    SRC_RX2,
    SRC_RY2,
    SRC_PX,
    SRC_PY,
    SRC_TX,
    SRC_YM,
    SRC_SQ
  } mer_src_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_LOAD_DEC
  } mer_acc_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_PY_ZERO,
    COND_REGION2,
    COND_DEC_NEG,
    COND_DEC_POS,
    COND_ACC_LT
  } mer_cond_t;

  typedef struct packed {
    mer_src_t              src_a;
    mer_src_t              src_b;
    mer_acc_t              acc_op;
    logic [1:0]            shift;
    logic                  init;
    logic                  rx2_we;
    logic                  ry2_we;
    logic                  sq_we;
    logic                  dec_we;
    logic                  px_inc;
    logic                  py_dec;
    logic                  r2_set;
    logic                  fin_set;
    logic                  emit;
    logic [1:0]            quad;
    logic                  wait_in;
    mer_cond_t             cond;
    logic [STEP_BITS-1:0]  target;
  } mer_uword_t;

  typedef struct packed {
    logic fin;
    logic region2;
    logic py_zero;
    logic dec_neg;
    logic dec_pos;
    logic acc_lt;
    logic out_busy;
  } mer_status_t;

  localparam mer_uword_t UW_NOP = '{
    src_a: SRC_ONE, src_b: SRC_ONE, acc_op: ACC_HOLD, shift: 2'd0,
    init: 1'b0, rx2_we: 1'b0, ry2_we: 1'b0, sq_we: 1'b0, dec_we: 1'b0,
    px_inc: 1'b0, py_dec: 1'b0, r2_set: 1'b0, fin_set: 1'b0, emit: 1'b0,
    quad: 2'd0, wait_in: 1'b0, cond: COND_NEXT, target: STEP_IDLE
  };

  // Microcode ROM. Each step multiplies src_a by src_b into the product
  // register and applies acc_op to the product of the previous step.
  function automatic mer_uword_t mer_ucode(input logic [STEP_BITS-1:0] addr);
    mer_uword_t uw;
    uw = UW_NOP;
    unique case (addr)
      // wait for a transaction
      STEP_IDLE: uw.wait_in = 1'b1;
      // restart: latch squares, decision = 4ry^2 - 4rx^2*ry + rx^2
      STEP_INIT: begin
        uw.init = 1'b1; uw.src_a = SRC_RX; uw.src_b = SRC_RX;
      end
      STEP_INIT + 6'd1: begin
        uw.rx2_we = 1'b1; uw.src_a = SRC_RY; uw.src_b = SRC_RY;
      end
      STEP_INIT + 6'd2: begin
        uw.ry2_we = 1'b1; uw.src_a = SRC_RX2; uw.src_b = SRC_PY;
        uw.acc_op = ACC_LOAD; uw.shift = 2'd2;
      end
      STEP_INIT + 6'd3: begin
        uw.src_a = SRC_RX2; uw.src_b = SRC_ONE;
        uw.acc_op = ACC_SUB; uw.shift = 2'd2;
      end
      STEP_INIT + 6'd4: uw.acc_op = ACC_ADD;
      STEP_INIT + 6'd5: uw.dec_we = 1'b1;
      // region test ry^2*x >= rx^2*y, then region-two decision
      STEP_CHECK: begin
        uw.src_a = SRC_RY2; uw.src_b = SRC_PX;
        uw.cond = COND_REGION2; uw.target = STEP_EMIT;
      end
      STEP_CHECK + 6'd1: begin
        uw.src_a = SRC_RX2; uw.src_b = SRC_PY; uw.acc_op = ACC_LOAD;
      end
      STEP_CHECK + 6'd2: begin
        uw.src_a = SRC_TX; uw.src_b = SRC_TX;
        uw.cond = COND_ACC_LT; uw.target = STEP_EMIT;
      end
      STEP_CHECK + 6'd3: begin
        uw.r2_set = 1'b1; uw.sq_we = 1'b1; uw.src_a = SRC_YM; uw.src_b = SRC_YM;
      end
      STEP_CHECK + 6'd4: begin
        uw.sq_we = 1'b1; uw.src_a = SRC_RY2; uw.src_b = SRC_SQ;
      end
      STEP_CHECK + 6'd5: begin
        uw.src_a = SRC_RX2; uw.src_b = SRC_SQ; uw.acc_op = ACC_LOAD;
      end
      STEP_CHECK + 6'd6: begin
        uw.src_a = SRC_RX2; uw.src_b = SRC_RY2;
        uw.acc_op = ACC_ADD; uw.shift = 2'd2;
      end
      STEP_CHECK + 6'd7: begin
        uw.acc_op = ACC_SUB; uw.shift = 2'd2;
      end
      STEP_CHECK + 6'd8: uw.dec_we = 1'b1;
      // four symmetric points
      STEP_EMIT:         begin uw.emit = 1'b1; uw.quad = 2'd0; end
      STEP_EMIT + 6'd1:  begin uw.emit = 1'b1; uw.quad = 2'd1; end
      STEP_EMIT + 6'd2:  begin uw.emit = 1'b1; uw.quad = 2'd2; end
      STEP_EMIT + 6'd3:  begin uw.emit = 1'b1; uw.quad = QUAD_LAST; end
      // advance one pixel
      STEP_ADV: begin
        uw.cond = COND_PY_ZERO; uw.target = STEP_FIN;
      end
      STEP_ADV + 6'd1: begin
        uw.cond = COND_REGION2; uw.target = STEP_R2;
      end
      STEP_ADV + 6'd2: begin
        uw.px_inc = 1'b1; uw.cond = COND_DEC_NEG; uw.target = STEP_R1_NEG;
      end
      STEP_ADV + 6'd3: uw.py_dec = 1'b1;
      STEP_ADV + 6'd4: begin
        uw.src_a = SRC_RY2; uw.src_b = SRC_PX; uw.acc_op = ACC_LOAD_DEC;
      end
      STEP_ADV + 6'd5: begin
        uw.src_a = SRC_RX2; uw.src_b = SRC_PY;
        uw.acc_op = ACC_ADD; uw.shift = 2'd3;
      end
      STEP_ADV + 6'd6: begin
        uw.src_a = SRC_RY2; uw.src_b = SRC_ONE;
        uw.acc_op = ACC_SUB; uw.shift = 2'd3;
      end
      STEP_ADV + 6'd7: begin
        uw.acc_op = ACC_ADD; uw.shift = 2'd2;
      end
      STEP_ADV + 6'd8: begin
        uw.dec_we = 1'b1; uw.cond = COND_ALWAYS; uw.target = STEP_IDLE;
      end
      STEP_R1_NEG: begin
        uw.src_a = SRC_RY2; uw.src_b = SRC_PX; uw.acc_op = ACC_LOAD_DEC;
      end
      STEP_R1_NEG + 6'd1: begin
        uw.src_a = SRC_RY2; uw.src_b = SRC_ONE;
        uw.acc_op = ACC_ADD; uw.shift = 2'd3;
      end
      STEP_R1_NEG + 6'd2: begin
        uw.acc_op = ACC_ADD; uw.shift = 2'd2;
      end
      STEP_R1_NEG + 6'd3: begin
        uw.dec_we = 1'b1; uw.cond = COND_ALWAYS; uw.target = STEP_IDLE;
      end
      STEP_R2: begin
        uw.py_dec = 1'b1; uw.cond = COND_DEC_POS; uw.target = STEP_R2_POS;
      end
      STEP_R2 + 6'd1: uw.px_inc = 1'b1;
      STEP_R2 + 6'd2: begin
        uw.src_a = SRC_RY2; uw.src_b = SRC_PX; uw.acc_op = ACC_LOAD_DEC;
      end
      STEP_R2 + 6'd3: begin
        uw.src_a = SRC_RX2; uw.src_b = SRC_PY;
        uw.acc_op = ACC_ADD; uw.shift = 2'd3;
      end
      STEP_R2 + 6'd4: begin
        uw.src_a = SRC_RX2; uw.src_b = SRC_ONE;
        uw.acc_op = ACC_SUB; uw.shift = 2'd3;
      end
      STEP_R2 + 6'd5: begin
        uw.acc_op = ACC_ADD; uw.shift = 2'd2;
      end
      STEP_R2 + 6'd6: begin
        uw.dec_we = 1'b1; uw.cond = COND_ALWAYS; uw.target = STEP_IDLE;
      end
      STEP_R2_POS: begin
        uw.src_a = SRC_RX2; uw.src_b = SRC_PY; uw.acc_op = ACC_LOAD_DEC;
      end
      STEP_R2_POS + 6'd1: begin
        uw.src_a = SRC_RX2; uw.src_b = SRC_ONE;
        uw.acc_op = ACC_SUB; uw.shift = 2'd3;
      end
      STEP_R2_POS + 6'd2: begin
        uw.acc_op = ACC_ADD; uw.shift = 2'd2;
      end
      STEP_R2_POS + 6'd3: begin
        uw.dec_we = 1'b1; uw.cond = COND_ALWAYS; uw.target = STEP_IDLE;
      end
      STEP_FIN: begin
        uw.fin_set = 1'b1; uw.cond = COND_ALWAYS; uw.target = STEP_IDLE;
      end
      default: begin
        uw.cond = COND_ALWAYS; uw.target = STEP_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

@@ rtl/core/mer_if.sv @@
// ----------------------------------------------------------------------------
// mer_if: stream channels of the midpoint ellipse rasterizer
// Valid/ready channels for start items and for plotted points.
// ----------------------------------------------------------------------------
interface mer_in_if;
  logic valid;
  logic ready;
  logic start_new;

  modport source (output valid, output start_new, input ready);
  modport sink   (input valid, input start_new, output ready);
endinterface

interface mer_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mer_pkg::OUT_BITS-1:0] point_x;
  logic signed [mer_pkg::OUT_BITS-1:0] point_y;
  logic                                last_of_pixel;
  logic                                final_pixel;

  modport source (output valid, output point_x, output point_y,
                  output last_of_pixel, output final_pixel, input ready);
  modport sink   (input valid, input point_x, input point_y,
                  input last_of_pixel, input final_pixel, output ready);
endinterface

@@ rtl/core/midpoint_ellipse_rasterizer.sv @@
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer: two-region midpoint ellipse outline generator
// Microcoded sequencer over one multiplier; emits four symmetric points per
// pixel through a registered output.
// ----------------------------------------------------------------------------
// Program center and radii first, then send a transaction with start_new set:
// it latches the squared radii, restarts at pixel (0, radius_y) and emits
// that pixel's four points. Each further transaction with start_new clear
// emits the next pixel; the pixel with y = 0 carries final_pixel, and after
// it transactions are consumed without producing points. Points come in the
// order (+x,+y), (-x,+y), (-x,-y), (+x,-y), the fourth with last_of_pixel.
// Input is taken one transaction at a time: a transaction runs the dispatch,
// the region test, the four point steps and the decision update (the pixel
// with y = 0 skips the update), a start first runs the init steps, the
// switch into region two adds the region-two setup steps, and a transaction
// after the outline is done only passes the dispatch. The microcode program
// runs every product through the single 24x24 multiplier one step at a time;
// output back-pressure holds the sequencer at an emit step. The center is
// read when each point is formed; new radii take effect at the next start.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer (
  input  logic                                clk,
  input  logic                                rst_n,
  mer_in_if.sink                              in_ch,
  mer_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [mer_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [mer_pkg::COORD_BITS-1:0]      cfg_data
);

  logic signed [mer_pkg::COORD_BITS-1:0] center_x_r;
  logic signed [mer_pkg::COORD_BITS-1:0] center_y_r;
  logic [mer_pkg::RADIUS_BITS-1:0]       radius_x_r;
  logic [mer_pkg::RADIUS_BITS-1:0]       radius_y_r;

  mer_pkg::mer_uword_t  uword;
  mer_pkg::mer_status_t status;

  // configuration registers, to be written only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_x_r <= '0;
      radius_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mer_pkg::CFG_CENTER_X: center_x_r <= cfg_data;
        mer_pkg::CFG_CENTER_Y: center_y_r <= cfg_data;
        mer_pkg::CFG_RADIUS_X: radius_x_r <= cfg_data[mer_pkg::RADIUS_BITS-1:0];
        mer_pkg::CFG_RADIUS_Y: radius_y_r <= cfg_data[mer_pkg::RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // step counter and microcode ROM
  mer_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_start (in_ch.start_new),
    .in_ready (in_ch.ready),
    .status   (status),
    .uword    (uword)
  );

  // pixel state, decision arithmetic and the output register
  mer_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .uword       (uword),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .radius_x    (radius_x_r),
    .radius_y    (radius_y_r),
    .status      (status),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_point_x (out_ch.point_x),
    .out_point_y (out_ch.point_y),
    .out_last    (out_ch.last_of_pixel),
    .out_final   (out_ch.final_pixel)
  );

  // a start transaction clears the finished flag once the init step has run
  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.start_new) |-> ##2 !status.fin)
    else $error("finished flag still set after a start transaction");

  // region two is left only through a restart
  a_region_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(status.region2) |-> $past(uword.init))
    else $error("region two cleared without a restart");

  // the outline ends only on the pixel with y = 0
  a_fin_at_y0: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(status.fin) && $past(rst_n)) |-> $past(status.py_zero))
    else $error("outline finished before y reached zero");

  // points leave only from the emit steps, never while input is taken
  a_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !uword.emit)
    else $error("emit step overlaps input dispatch");

endmodule

@@ rtl/core/mer_seq.sv @@
// ----------------------------------------------------------------------------
// mer_seq: microcode sequencer
// Step counter over the microcode ROM with conditional jumps, input
// dispatch at the idle step and hold while the output register is full.
// ----------------------------------------------------------------------------
module mer_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_start,
  output logic                 in_ready,
  input  mer_pkg::mer_status_t status,
  output mer_pkg::mer_uword_t  uword
);

  logic [mer_pkg::STEP_BITS-1:0] step_r;
  logic [mer_pkg::STEP_BITS-1:0] step_nxt;
  logic                          cond_hit;

  assign uword = mer_pkg::mer_ucode(step_r);

  always_comb begin
    unique case (uword.cond)
      mer_pkg::COND_NEXT:    cond_hit = 1'b0;
      mer_pkg::COND_ALWAYS:  cond_hit = 1'b1;
      mer_pkg::COND_PY_ZERO: cond_hit = status.py_zero;
      mer_pkg::COND_REGION2: cond_hit = status.region2;
      mer_pkg::COND_DEC_NEG: cond_hit = status.dec_neg;
      mer_pkg::COND_DEC_POS: cond_hit = status.dec_pos;
      mer_pkg::COND_ACC_LT:  cond_hit = status.acc_lt;
      default:               cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    in_ready = uword.wait_in;
    priority if (uword.wait_in) begin
      if (!in_valid) begin
        step_nxt = mer_pkg::STEP_IDLE;
      end else if (in_start) begin
        step_nxt = mer_pkg::STEP_INIT;
      end else if (status.fin) begin
        step_nxt = mer_pkg::STEP_IDLE;
      end else begin
        step_nxt = mer_pkg::STEP_CHECK;
      end
    end else if (uword.emit && status.out_busy) begin
      step_nxt = step_r;
    end else if (cond_hit) begin
      step_nxt = uword.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= mer_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ rtl/core/mer_dp.sv @@
// ----------------------------------------------------------------------------
// mer_dp: rasterizer datapath
// Pixel and decision registers, one registered multiplier, an accumulator
// and the output register for plotted points.
// ----------------------------------------------------------------------------
module mer_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mer_pkg::mer_uword_t                  uword,
  input  logic signed [mer_pkg::COORD_BITS-1:0] center_x,
  input  logic signed [mer_pkg::COORD_BITS-1:0] center_y,
  input  logic [mer_pkg::RADIUS_BITS-1:0]      radius_x,
  input  logic [mer_pkg::RADIUS_BITS-1:0]      radius_y,
  output mer_pkg::mer_status_t                 status,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [mer_pkg::OUT_BITS-1:0]  out_point_x,
  output logic signed [mer_pkg::OUT_BITS-1:0]  out_point_y,
  output logic                                 out_last,
  output logic                                 out_final
);

  logic [mer_pkg::RADIUS_BITS-1:0] px_r;
  logic [mer_pkg::RADIUS_BITS-1:0] py_r;
  logic [mer_pkg::DEC_BITS-1:0]    dec_r;
  logic [mer_pkg::DEC_BITS-1:0]    acc_r;
  logic [mer_pkg::DEC_BITS-1:0]    acc_nxt;
  logic [mer_pkg::PROD_BITS-1:0]   prod_r;
  logic [mer_pkg::SQR_BITS-1:0]    rx2_r;
  logic [mer_pkg::SQR_BITS-1:0]    ry2_r;
  logic [mer_pkg::MUL_BITS-1:0]    sq_r;
  logic                            r2_r;
  logic                            fin_r;

  logic [mer_pkg::MUL_BITS-1:0]    op_a;
  logic [mer_pkg::MUL_BITS-1:0]    op_b;
  logic [mer_pkg::DEC_BITS-1:0]    prod_sh;
  logic [mer_pkg::RADIUS_BITS-1:0] ym;
  logic [mer_pkg::RADIUS_BITS:0]   tx;
  logic                            out_load;
  logic signed [mer_pkg::OUT_BITS-1:0] cx_ext;
  logic signed [mer_pkg::OUT_BITS-1:0] cy_ext;
  logic signed [mer_pkg::OUT_BITS-1:0] px_ext;
  logic signed [mer_pkg::OUT_BITS-1:0] py_ext;

  // |y-1| squares the same as y-1, also when y is zero
  assign ym = (py_r == '0) ? mer_pkg::RADIUS_BITS'(1) : py_r - 1'b1;
  assign tx = {px_r, 1'b1};

  function automatic logic [mer_pkg::MUL_BITS-1:0] pick(
    input mer_pkg::mer_src_t               sel,
    input logic [mer_pkg::RADIUS_BITS-1:0] rx,
    input logic [mer_pkg::RADIUS_BITS-1:0] ry,
    input logic [mer_pkg::SQR_BITS-1:0]    rx2,
    input logic [mer_pkg::SQR_BITS-1:0]    ry2,
    input logic [mer_pkg::RADIUS_BITS-1:0] px,
    input logic [mer_pkg::RADIUS_BITS-1:0] py,
    input logic [mer_pkg::RADIUS_BITS:0]   txv,
    input logic [mer_pkg::RADIUS_BITS-1:0] ymv,
    input logic [mer_pkg::MUL_BITS-1:0]    sq
  );
    logic [mer_pkg::MUL_BITS-1:0] v;
    unique case (sel)
      mer_pkg::SRC_ONE: v = mer_pkg::MUL_BITS'(1);
      mer_pkg::SRC_RX:  v = mer_pkg::MUL_BITS'(rx);
      mer_pkg::SRC_RY:  v = mer_pkg::MUL_BITS'(ry);
      mer_pkg::SRC_RX2: v = mer_pkg::MUL_BITS'(rx2);
      mer_pkg::SRC_RY2: v = mer_pkg::MUL_BITS'(ry2);
      mer_pkg::SRC_PX:  v = mer_pkg::MUL_BITS'(px);
      mer_pkg::SRC_PY:  v = mer_pkg::MUL_BITS'(py);
      mer_pkg::SRC_TX:  v = mer_pkg::MUL_BITS'(txv);
      mer_pkg::SRC_YM:  v = mer_pkg::MUL_BITS'(ymv);
      mer_pkg::SRC_SQ:  v = sq;
      default:          v = '0;
    endcase
    return v;
  endfunction

  assign op_a = pick(uword.src_a, radius_x, radius_y, rx2_r, ry2_r,
                     px_r, py_r, tx, ym, sq_r);
  assign op_b = pick(uword.src_b, radius_x, radius_y, rx2_r, ry2_r,
                     px_r, py_r, tx, ym, sq_r);

  assign prod_sh = mer_pkg::DEC_BITS'(prod_r) << uword.shift;

  always_comb begin
    unique case (uword.acc_op)
      mer_pkg::ACC_HOLD:     acc_nxt = acc_r;
      mer_pkg::ACC_LOAD:     acc_nxt = prod_sh;
      mer_pkg::ACC_ADD:      acc_nxt = acc_r + prod_sh;
      mer_pkg::ACC_SUB:      acc_nxt = acc_r - prod_sh;
      mer_pkg::ACC_LOAD_DEC: acc_nxt = dec_r;
      default:               acc_nxt = acc_r;
    endcase
  end

  assign status.fin      = fin_r;
  assign status.region2  = r2_r;
  assign status.py_zero  = (py_r == '0);
  assign status.dec_neg  = dec_r[mer_pkg::DEC_BITS-1];
  assign status.dec_pos  = !dec_r[mer_pkg::DEC_BITS-1] && (dec_r != '0);
  assign status.acc_lt   = acc_r < mer_pkg::DEC_BITS'(prod_r);
  assign status.out_busy = out_valid && !out_ready;

  assign out_load = uword.emit && !status.out_busy;

  assign cx_ext = mer_pkg::OUT_BITS'(center_x);
  assign cy_ext = mer_pkg::OUT_BITS'(center_y);
  assign px_ext = mer_pkg::OUT_BITS'(px_r);
  assign py_ext = mer_pkg::OUT_BITS'(py_r);

  always_ff @(posedge clk) begin
    prod_r <= mer_pkg::PROD_BITS'(op_a) * mer_pkg::PROD_BITS'(op_b);
    acc_r  <= acc_nxt;
    if (uword.sq_we) begin
      sq_r <= prod_r[mer_pkg::MUL_BITS-1:0];
    end
    // quadrant order: (+x,+y) (-x,+y) (-x,-y) (+x,-y)
    if (out_load) begin
      out_point_x <= (uword.quad[0] ^ uword.quad[1]) ? cx_ext - px_ext : cx_ext + px_ext;
      out_point_y <= uword.quad[1] ? cy_ext - py_ext : cy_ext + py_ext;
      out_last    <= (uword.quad == mer_pkg::QUAD_LAST);
      out_final   <= (py_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r      <= '0;
      py_r      <= '0;
      dec_r     <= '0;
      rx2_r     <= '0;
      ry2_r     <= '0;
      r2_r      <= 1'b0;
      fin_r     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (uword.init) begin
        px_r  <= '0;
        py_r  <= radius_y;
        r2_r  <= 1'b0;
        fin_r <= 1'b0;
      end
      // saturate x at the top of its range
      if (uword.px_inc && (px_r != '1)) begin
        px_r <= px_r + 1'b1;
      end
      if (uword.py_dec) begin
        py_r <= py_r - 1'b1;
      end
      if (uword.rx2_we) begin
        rx2_r <= prod_r[mer_pkg::SQR_BITS-1:0];
      end
      if (uword.ry2_we) begin
        ry2_r <= prod_r[mer_pkg::SQR_BITS-1:0];
      end
      if (uword.dec_we) begin
        dec_r <= acc_r;
      end
      if (uword.r2_set) begin
        r2_r <= 1'b1;
      end
      if (uword.fin_set) begin
        fin_r <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
